// ===== hdl/dpu_pkg.sv =====
// Shared constants, register indexes and the multiplier operand type
// of the depth pixel unprojector. Depends on nothing.
package dpu_pkg;

  // Frame and capacity limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_POINTS = 16777216;

  // Field and counter widths
  localparam int COUNT_W = 12;
  localparam int SIZE_W  = 13;
  localparam int KEEP_W  = 25;
  localparam int MAG_W   = 17;
  localparam int DATA_W  = 25;
  localparam int INDEX_W = 3;

  // Shared multiplier: 32 x 25 unsigned, registered product
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_DEPTH_SCALE    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_CENTER_X       = 3'd1;
  localparam logic [INDEX_W-1:0] REG_CENTER_Y       = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RECIP_FOCAL_X  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_RECIP_FOCAL_Y  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd5;
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd6;
  localparam logic [INDEX_W-1:0] REG_POINT_CAPACITY = 3'd7;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

  // Map a size of zero to one and cap it at the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/dpu_mul.sv =====
// Shared unsigned multiplier of the unprojector with a registered product.
// Depends on dpu_pkg for the operand type and widths.
module dpu_mul (
  input  logic                      clk,
  input  dpu_pkg::mul_op_t          op,
  output logic [dpu_pkg::MUL_P_W-1:0] prod
);
  import dpu_pkg::*;

  // Register the product of the two operands
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
  end

endmodule

// ===== hdl/depth_pixel_unprojector.sv =====
// Channel  | Signals                                  | Direction
// pixel    | pixel_valid, pixel_stall, raw_depth      | in (stall out)
// point    | point_valid, point_stall, point_x/y/z,   | out (stall in)
//          | kept, frame_end, points_used             |
// config   | cfg_write, cfg_index, cfg_data           | in
//
// A kept pixel steps through states S_Z to S_AY, in which seven products pass
// one after another through the single 32x25 multiplier, and then to S_WB.
// A pixel that is not kept goes straight to S_WB. pixel_stall is high while busy.
// A finished transaction waits in the output register while point_stall is high.
// rst (synchronous) loads register defaults and clears counters and valid.
// Top level of the depth pixel unprojector; depends on dpu_pkg and dpu_mul.
module depth_pixel_unprojector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic [15:0]                 raw_depth,
  output logic                        point_valid,
  input  logic                        point_stall,
  output logic signed [31:0]          point_x,
  output logic signed [31:0]          point_y,
  output logic [31:0]                 point_z,
  output logic                        kept,
  output logic                        frame_end,
  output logic [dpu_pkg::KEEP_W-1:0]  points_used,
  input  logic                        cfg_write,
  input  logic [dpu_pkg::INDEX_W-1:0] cfg_index,
  input  logic [dpu_pkg::DATA_W-1:0]  cfg_data
);
  import dpu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_Z    = 4'd1;
  localparam logic [3:0] S_MX   = 4'd2;
  localparam logic [3:0] S_LX   = 4'd3;
  localparam logic [3:0] S_HX   = 4'd4;
  localparam logic [3:0] S_AX   = 4'd5;
  localparam logic [3:0] S_LY   = 4'd6;
  localparam logic [3:0] S_HY   = 4'd7;
  localparam logic [3:0] S_AY   = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;

  // Configuration registers
  logic [23:0]         depth_scale;
  logic [15:0]         center_x;
  logic [15:0]         center_y;
  logic [24:0]         recip_focal_x;
  logic [24:0]         recip_focal_y;
  logic [SIZE_W-1:0]   frame_width;
  logic [SIZE_W-1:0]   frame_height;
  logic [KEEP_W-1:0]   point_capacity;

  // Frame position and kept count
  logic [COUNT_W-1:0]  column_count;
  logic [COUNT_W-1:0]  row_count;
  logic [KEEP_W-1:0]   kept_count;

  logic [3:0]          state;
  logic [3:0]          state_next;

  // Latched item
  logic [15:0]         raw;
  logic [MAG_W-1:0]    mag_x;
  logic [MAG_W-1:0]    mag_y;
  logic                neg_x;
  logic                neg_y;
  logic                item_keep;
  logic                item_fend;
  logic [KEEP_W-1:0]   item_used;

  // Working registers of the sequence
  logic [31:0]         z;
  logic [24:0]         m_hi;
  logic [24:0]         lo_part;
  logic [31:0]         coord_x;
  logic [31:0]         coord_y;

  mul_op_t             op;
  logic [MUL_P_W-1:0]  prod;

  logic                accept;
  logic [SIZE_W-1:0]   width_eff;
  logic [SIZE_W-1:0]   height_eff;
  logic [SIZE_W-1:0]   col_inc;
  logic [SIZE_W-1:0]   row_inc;
  logic                last_col;
  logic                last_row;
  logic                fend_now;
  logic [KEEP_W-1:0]   cap;
  logic                keep_now;
  logic [KEEP_W-1:0]   used_now;
  logic [17:0]         dx;
  logic [17:0]         dy;
  logic [17:0]         dx_abs;
  logic [17:0]         dy_abs;
  logic [50:0]         sum;
  logic [31:0]         coord_sat;
  logic                coord_neg;
  logic                out_free;

  // Clip a signed magnitude to the Q16.16 range
  function automatic logic [31:0] saturate(input logic [46:0] v, input logic neg);
    logic        big;
    logic [31:0] r;
    big = |v[46:31];
    if (neg) begin
      r = big ? 32'h8000_0000 : (32'd0 - v[31:0]);
    end else begin
      r = big ? 32'h7FFF_FFFF : v[31:0];
    end
    return r;
  endfunction

  dpu_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign out_free    = !point_valid || !point_stall;

  // Frame position tests and capacity check for the incoming pixel
  always_comb begin
    width_eff  = clamp_size(frame_width, SIZE_W'(MAX_WIDTH));
    height_eff = clamp_size(frame_height, SIZE_W'(MAX_HEIGHT));
    col_inc    = {1'b0, column_count} + SIZE_W'(1);
    row_inc    = {1'b0, row_count} + SIZE_W'(1);
    last_col   = (col_inc >= width_eff);
    last_row   = (row_inc >= height_eff);
    fend_now   = last_col && last_row;
    cap        = (point_capacity > KEEP_W'(MAX_POINTS)) ? KEEP_W'(MAX_POINTS)
                                                        : point_capacity;
    keep_now   = (kept_count < cap);
    used_now   = keep_now ? (kept_count + KEEP_W'(1)) : kept_count;
    dx         = {2'b00, column_count, 4'b0000} - {2'b00, center_x};
    dy         = {2'b00, row_count, 4'b0000} - {2'b00, center_y};
    dx_abs     = dx[17] ? (18'd0 - dx) : dx;
    dy_abs     = dy[17] ? (18'd0 - dy) : dy;
  end

  // Final add of the split product, drop four fraction bits, saturate
  always_comb begin
    sum       = {1'b0, prod[49:0]} + 51'(lo_part);
    coord_neg = (state == S_AX) ? neg_x : neg_y;
    coord_sat = saturate(sum[50:4], coord_neg);
  end

  // Multiplier operands for each step
  always_comb begin
    op = '0;
    unique case (state)
      S_Z:  begin
        op.a = MUL_A_W'(raw);
        op.b = MUL_B_W'(depth_scale);
      end
      S_MX: begin
        op.a = prod[39:8];
        op.b = MUL_B_W'(mag_x);
      end
      S_LX: begin
        op.a = MUL_A_W'(prod[23:0]);
        op.b = recip_focal_x;
      end
      S_HX: begin
        op.a = MUL_A_W'(m_hi);
        op.b = recip_focal_x;
      end
      S_AX: begin
        op.a = z;
        op.b = MUL_B_W'(mag_y);
      end
      S_LY: begin
        op.a = MUL_A_W'(prod[23:0]);
        op.b = recip_focal_y;
      end
      S_HY: begin
        op.a = MUL_A_W'(m_hi);
        op.b = recip_focal_y;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = keep_now ? S_Z : S_WB;
        end
      end
      S_Z:  state_next = S_MX;
      S_MX: state_next = S_LX;
      S_LX: state_next = S_HX;
      S_HX: state_next = S_AX;
      S_AX: state_next = S_LY;
      S_LY: state_next = S_HY;
      S_HY: state_next = S_AY;
      S_AY: state_next = S_WB;
      S_WB: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state, configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      point_valid    <= 1'b0;
      column_count   <= '0;
      row_count      <= '0;
      kept_count     <= '0;
      depth_scale    <= 24'd1678;
      center_x       <= 16'd5120;
      center_y       <= 16'd3840;
      recip_focal_x  <= 25'd27962;
      recip_focal_y  <= 25'd27962;
      frame_width    <= SIZE_W'(640);
      frame_height   <= SIZE_W'(480);
      point_capacity <= KEEP_W'(307200);
    end else begin
      state <= state_next;

      // Output register: load on write-back, drop once taken
      if (state == S_WB && out_free) begin
        point_valid <= 1'b1;
      end else if (point_valid && !point_stall) begin
        point_valid <= 1'b0;
      end

      // Advance the raster position
      if (accept) begin
        if (fend_now) begin
          column_count <= '0;
          row_count    <= '0;
          kept_count   <= '0;
        end else begin
          kept_count <= used_now;
          if (last_col) begin
            column_count <= '0;
            row_count    <= row_count + COUNT_W'(1);
          end else begin
            column_count <= column_count + COUNT_W'(1);
          end
        end
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEPTH_SCALE:    depth_scale    <= cfg_data[23:0];
          REG_CENTER_X:       center_x       <= cfg_data[15:0];
          REG_CENTER_Y:       center_y       <= cfg_data[15:0];
          REG_RECIP_FOCAL_X:  recip_focal_x  <= cfg_data;
          REG_RECIP_FOCAL_Y:  recip_focal_y  <= cfg_data;
          REG_FRAME_WIDTH:    frame_width    <= cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT:   frame_height   <= cfg_data[SIZE_W-1:0];
          REG_POINT_CAPACITY: point_capacity <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      raw       <= raw_depth;
      mag_x     <= dx_abs[MAG_W-1:0];
      mag_y     <= dy_abs[MAG_W-1:0];
      neg_x     <= dx[17];
      neg_y     <= !dy[17];
      item_keep <= keep_now;
      item_fend <= fend_now;
      item_used <= used_now;
    end
    if (state == S_MX) begin
      z <= prod[39:8];
    end
    if (state == S_LX || state == S_LY) begin
      m_hi <= prod[48:24];
    end
    if (state == S_HX || state == S_HY) begin
      lo_part <= prod[48:24];
    end
    if (state == S_AX) begin
      coord_x <= coord_sat;
    end
    if (state == S_AY) begin
      coord_y <= coord_sat;
    end
    if (state == S_WB && out_free) begin
      point_x     <= item_keep ? coord_x : 32'd0;
      point_y     <= item_keep ? coord_y : 32'd0;
      point_z     <= item_keep ? z : 32'd0;
      kept        <= item_keep;
      frame_end   <= item_fend;
      points_used <= item_used;
    end
  end

  // A dropped point carries no coordinates
  assert property (@(posedge clk) disable iff (rst)
    point_valid && !kept |-> point_x == 0 && point_y == 0 && point_z == 0)
    else $error("dropped point with non-zero coordinates");

  // A kept point always counts itself
  assert property (@(posedge clk) disable iff (rst)
    point_valid && kept |-> points_used != 0)
    else $error("kept point reports zero points used");

  // The last pixel of a frame restarts all counters
  assert property (@(posedge clk) disable iff (rst)
    accept && fend_now |=> column_count == 0 && row_count == 0 && kept_count == 0)
    else $error("counters not cleared after frame end");

  // An accepted pixel starts the product sequence or goes straight to write-back
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_Z || state == S_WB)
    else $error("sequencer did not start after acceptance");

endmodule
